// ----- rtl/spkeq_pkg.sv -----
// ----------------------------------------------------------------------------
// spkeq_pkg
// Shared types, constants and coefficient tables for the speaker equalizer
// biquad cascade (high-pass followed by a presence peaking boost).
// ----------------------------------------------------------------------------
package spkeq_pkg;

    // sample and stage signal formats
    localparam int SAMPLE_W        = 16;
    localparam int SIG_W           = 24;
    localparam int SIG_FRAC        = 6;
    localparam int N_STAGE         = 2;
    localparam int N_COEF          = 5;

    // default arithmetic widths
    localparam int COEF_WIDTH_DEF  = 32;
    localparam int DELAY_WIDTH_DEF = 48;

    // Q2.30 coefficients: b0, b1, b2, a1, a2
    localparam logic signed [63:0] HP_Q30 [N_COEF] = '{
        64'sd987902066, -64'sd1975804132, 64'sd987902066,
        -64'sd1968932631, 64'sd908933808
    };
    localparam logic signed [63:0] PK_Q30 [N_COEF] = '{
        64'sd1242325275, 64'sd601205132, 64'sd328699446,
        64'sd601205132, 64'sd497282897
    };

    // coefficient select
    typedef enum logic [2:0] {
        C_B0,
        C_B1,
        C_B2,
        C_A1,
        C_A2
    } t_coef_sel;

    // accumulator operation
    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_P_D0,
        ACC_LOAD_P,
        ACC_SUB_P,
        ACC_ADD_D1
    } t_acc_op;

    // controller to datapath command word
    typedef struct packed {
        logic      load;
        logic      stage;
        logic      mul_en;
        t_coef_sel coef_sel;
        logic      mul_src_y;
        t_acc_op   acc_op;
        logic      y_load;
        logic      d0_wr;
        logic      d1_wr;
        logic      stage_adv;
        logic      out_load;
    } t_dp_cmd;

    // move a Q2.30 coefficient to cw-2 fraction bits, rounding half up
    function automatic logic signed [63:0] spkeq_coef(input logic signed [63:0] q30,
                                                      input int cw);
        int                 sh;
        logic signed [63:0] res;
        sh = 32 - cw;
        if (sh > 0) begin
            res = (q30 >>> sh) + ((q30 >> (sh - 1)) & 64'sd1);
        end else begin
            res = q30 <<< (-sh);
        end
        return res;
    endfunction

endpackage

// ----- rtl/spkeq_in_if.sv -----
// ----------------------------------------------------------------------------
// spkeq_in_if
// Input sample channel: valid/ready with one PCM sample and a chunk flag.
// ----------------------------------------------------------------------------
interface spkeq_in_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [spkeq_pkg::SAMPLE_W-1:0]   sample_in;
    logic                                    chunk_start;

    modport source (output valid, output sample_in, output chunk_start, input ready);
    modport sink   (input valid, input sample_in, input chunk_start, output ready);
endinterface

// ----- rtl/spkeq_out_if.sv -----
// ----------------------------------------------------------------------------
// spkeq_out_if
// Output sample channel: valid/ready with one equalized sample.
// ----------------------------------------------------------------------------
interface spkeq_out_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [spkeq_pkg::SAMPLE_W-1:0]   sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

// ----- rtl/speaker_equalizer_biquad_cascade_unit.sv -----
// ----------------------------------------------------------------------------
// speaker_equalizer_biquad_cascade_unit
// Two cascaded transposed direct-form-II biquads (150 Hz high-pass, then a
// +4 dB peaking boost at 2500 Hz) on 16-bit samples, output saturated.
// ----------------------------------------------------------------------------
//  channel   direction  payload                        handshake
//  i_in      in         sample_in[15:0], chunk_start   valid / ready
//  o_out     out        sample_out[15:0]               valid / ready
//
//  a sample is accepted, then runs nine steps per biquad on the
//  single shared coefficient multiplier and accumulator, then loads output
//  the next sample is taken while a finished sample waits on o_out
//  a result waiting on o_out holds the sequencer before its output load
//  i_rst_n is synchronous and clears sequencer and filter delays at once
//  chunk_start clears all four delays before that sample is filtered
// ----------------------------------------------------------------------------
module speaker_equalizer_biquad_cascade_unit #(
    parameter int COEF_WIDTH  = spkeq_pkg::COEF_WIDTH_DEF,
    parameter int DELAY_WIDTH = spkeq_pkg::DELAY_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    spkeq_in_if.sink      i_in,
    spkeq_out_if.source   o_out
);
    import spkeq_pkg::*;

    t_dp_cmd w_cmd;
    logic    w_in_ready;
    logic    w_out_valid;

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;

    // sequencer
    spkeq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd)
    );

    // arithmetic and state
    spkeq_datapath #(
        .COEF_WIDTH  (COEF_WIDTH),
        .DELAY_WIDTH (DELAY_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_sample_in   (i_in.sample_in),
        .i_chunk_start (i_in.chunk_start),
        .o_sample_out  (o_out.sample_out)
    );

endmodule

// ----- rtl/spkeq_ctrl.sv -----
// ----------------------------------------------------------------------------
// spkeq_ctrl
// Sequencer for the biquad cascade: walks nine micro-steps per biquad over
// the shared multiplier and accumulator, then loads the output register.
// ----------------------------------------------------------------------------
module spkeq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output spkeq_pkg::t_dp_cmd  o_cmd
);
    import spkeq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FIN
    } t_state;

    typedef enum logic [3:0] {
        SP_MUL_B0,
        SP_ACC_D0,
        SP_LOAD_Y,
        SP_MUL_A1,
        SP_SUB_A1,
        SP_ADD_D1,
        SP_WR_D0,
        SP_SUB_A2,
        SP_WR_D1
    } t_step;

    t_state  r_state;
    t_step   r_step;
    logic    r_stage;
    logic    r_out_valid;
    logic    w_accept;
    logic    w_out_free;
    t_dp_cmd w_cmd;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_cmd       = w_cmd;

    // command decode per micro-step
    always_comb begin
        w_cmd           = '0;
        w_cmd.coef_sel  = C_B0;
        w_cmd.acc_op    = ACC_HOLD;
        w_cmd.load      = w_accept;
        w_cmd.stage     = r_stage;
        if (r_state == S_RUN) begin
            case (r_step)
                SP_MUL_B0: begin
                    w_cmd.mul_en   = 1'b1;
                    w_cmd.coef_sel = C_B0;
                end
                SP_ACC_D0: begin
                    w_cmd.acc_op   = ACC_P_D0;
                    w_cmd.mul_en   = 1'b1;
                    w_cmd.coef_sel = C_B1;
                end
                SP_LOAD_Y: begin
                    w_cmd.y_load = 1'b1;
                    w_cmd.acc_op = ACC_LOAD_P;
                end
                SP_MUL_A1: begin
                    w_cmd.mul_en    = 1'b1;
                    w_cmd.coef_sel  = C_A1;
                    w_cmd.mul_src_y = 1'b1;
                end
                SP_SUB_A1: begin
                    w_cmd.acc_op = ACC_SUB_P;
                end
                SP_ADD_D1: begin
                    w_cmd.acc_op   = ACC_ADD_D1;
                    w_cmd.mul_en   = 1'b1;
                    w_cmd.coef_sel = C_B2;
                end
                SP_WR_D0: begin
                    w_cmd.d0_wr     = 1'b1;
                    w_cmd.acc_op    = ACC_LOAD_P;
                    w_cmd.mul_en    = 1'b1;
                    w_cmd.coef_sel  = C_A2;
                    w_cmd.mul_src_y = 1'b1;
                end
                SP_SUB_A2: begin
                    w_cmd.acc_op = ACC_SUB_P;
                end
                SP_WR_D1: begin
                    w_cmd.d1_wr     = 1'b1;
                    w_cmd.stage_adv = !r_stage;
                end
                default: begin
                    w_cmd.acc_op = ACC_HOLD;
                end
            endcase
        end
        if ((r_state == S_FIN) && w_out_free) begin
            w_cmd.out_load = 1'b1;
        end
    end

    // state, step counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= SP_MUL_B0;
            r_stage     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_RUN;
                        r_step  <= SP_MUL_B0;
                        r_stage <= 1'b0;
                    end
                end
                S_RUN: begin
                    if (r_step == SP_WR_D1) begin
                        r_step <= SP_MUL_B0;
                        if (r_stage) begin
                            r_state <= S_FIN;
                        end else begin
                            r_stage <= 1'b1;
                        end
                    end else begin
                        r_step <= t_step'(4'(r_step + 4'd1));
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // a transaction on the input starts a run at once
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (!o_in_ready && (r_step == SP_MUL_B0)))
        else $error("input taken but sequencer did not start");

    // a finished sample never overwrites one still waiting
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten while pending");

    // the second biquad starts from its first step
    a_stage_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.stage_adv |=> (r_stage && (r_step == SP_MUL_B0) && (r_state == S_RUN)))
        else $error("stage advance lost");

endmodule

// ----- rtl/spkeq_datapath.sv -----
// ----------------------------------------------------------------------------
// spkeq_datapath
// Shared coefficient multiplier with product alignment, saturating
// accumulator, per-biquad delay registers and the output formatter.
// ----------------------------------------------------------------------------
module spkeq_datapath #(
    parameter int COEF_WIDTH  = spkeq_pkg::COEF_WIDTH_DEF,
    parameter int DELAY_WIDTH = spkeq_pkg::DELAY_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  spkeq_pkg::t_dp_cmd                    i_cmd,
    input  logic signed [spkeq_pkg::SAMPLE_W-1:0] i_sample_in,
    input  logic                                  i_chunk_start,
    output logic signed [spkeq_pkg::SAMPLE_W-1:0] o_sample_out
);
    import spkeq_pkg::*;

    localparam int CW    = COEF_WIDTH;
    localparam int DW    = DELAY_WIDTH;
    localparam int PW    = CW + SIG_W;
    localparam int EW    = ((PW > DW) ? PW : DW) + 1;
    localparam int ALIGN = CW - DW + 28;
    localparam int YS    = DW - 30;
    localparam int YW    = DW - YS + 1;

    // coefficients converted to CW-2 fraction bits at elaboration
    localparam logic signed [CW-1:0] K_TAB [N_STAGE][N_COEF] = '{
        '{CW'(spkeq_coef(HP_Q30[0], CW)), CW'(spkeq_coef(HP_Q30[1], CW)),
          CW'(spkeq_coef(HP_Q30[2], CW)), CW'(spkeq_coef(HP_Q30[3], CW)),
          CW'(spkeq_coef(HP_Q30[4], CW))},
        '{CW'(spkeq_coef(PK_Q30[0], CW)), CW'(spkeq_coef(PK_Q30[1], CW)),
          CW'(spkeq_coef(PK_Q30[2], CW)), CW'(spkeq_coef(PK_Q30[3], CW)),
          CW'(spkeq_coef(PK_Q30[4], CW))}
    };

    logic signed [SIG_W-1:0]    r_x;
    logic signed [SIG_W-1:0]    r_y;
    logic signed [DW-1:0]       r_prod;
    logic signed [DW-1:0]       r_acc;
    logic signed [DW-1:0]       r_d0 [N_STAGE];
    logic signed [DW-1:0]       r_d1 [N_STAGE];
    logic signed [SAMPLE_W-1:0] r_out;

    logic signed [CW-1:0]       w_coef;
    logic signed [SIG_W-1:0]    w_opd;
    logic signed [PW-1:0]       w_mul;
    logic signed [EW-1:0]       w_ext;
    logic signed [DW-1:0]       w_aligned;
    logic signed [DW-1:0]       w_op_a;
    logic signed [DW-1:0]       w_op_b;
    logic                       w_sub;
    logic signed [DW:0]         w_sum;
    logic signed [DW-1:0]       w_sat;
    logic signed [DW-1:0]       n_acc;
    logic signed [YW-1:0]       w_yq;
    logic signed [SIG_W-1:0]    w_ysat;
    logic signed [SIG_W:0]      w_ybias;
    logic signed [SIG_W-SIG_FRAC:0] w_q;
    logic signed [SAMPLE_W-1:0] w_qsat;

    assign o_sample_out = r_out;

    // coefficient and operand selection
    always_comb begin
        case (i_cmd.coef_sel)
            C_B0:    w_coef = K_TAB[i_cmd.stage][0];
            C_B1:    w_coef = K_TAB[i_cmd.stage][1];
            C_B2:    w_coef = K_TAB[i_cmd.stage][2];
            C_A1:    w_coef = K_TAB[i_cmd.stage][3];
            C_A2:    w_coef = K_TAB[i_cmd.stage][4];
            default: w_coef = '0;
        endcase
    end
    assign w_opd = i_cmd.mul_src_y ? r_y : r_x;

    // shared multiplier and alignment to the delay format
    assign w_mul = w_coef * w_opd;
    assign w_ext = EW'(w_mul);
    generate
        if (ALIGN > 0) begin : g_align_right
            logic signed [EW-1:0] w_shr;
            assign w_shr     = (w_ext >>> ALIGN) + EW'($signed({1'b0, w_mul[ALIGN-1]}));
            assign w_aligned = DW'(w_shr);
        end else if (ALIGN < 0) begin : g_align_left
            logic signed [EW-1:0] w_shl;
            assign w_shl     = w_ext <<< (-ALIGN);
            assign w_aligned = DW'(w_shl);
        end else begin : g_align_none
            assign w_aligned = DW'(w_ext);
        end
    endgenerate

    // saturating accumulator
    always_comb begin
        w_op_a = r_acc;
        w_op_b = r_prod;
        w_sub  = 1'b0;
        case (i_cmd.acc_op)
            ACC_P_D0: begin
                w_op_a = r_prod;
                w_op_b = r_d0[i_cmd.stage];
            end
            ACC_SUB_P: begin
                w_sub = 1'b1;
            end
            ACC_ADD_D1: begin
                w_op_b = r_d1[i_cmd.stage];
            end
            default: begin
                w_sub = 1'b0;
            end
        endcase
        if (w_sub) begin
            w_sum = {w_op_a[DW-1], w_op_a} - {w_op_b[DW-1], w_op_b};
        end else begin
            w_sum = {w_op_a[DW-1], w_op_a} + {w_op_b[DW-1], w_op_b};
        end
        if (w_sum[DW] != w_sum[DW-1]) begin
            w_sat = w_sum[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end else begin
            w_sat = w_sum[DW-1:0];
        end
        case (i_cmd.acc_op)
            ACC_P_D0, ACC_SUB_P, ACC_ADD_D1: n_acc = w_sat;
            ACC_LOAD_P:                      n_acc = r_prod;
            default:                         n_acc = r_acc;
        endcase
    end

    // stage output: round half up to 6 fraction bits, clamp to 24 bits
    always_comb begin
        w_yq = YW'(r_acc >>> YS) + YW'($signed({1'b0, r_acc[YS-1]}));
        if ((&w_yq[YW-1:SIG_W-1]) || !(|w_yq[YW-1:SIG_W-1])) begin
            w_ysat = w_yq[SIG_W-1:0];
        end else begin
            w_ysat = w_yq[YW-1] ? {1'b1, {(SIG_W-1){1'b0}}} : {1'b0, {(SIG_W-1){1'b1}}};
        end
    end

    // final sample: drop fraction toward zero, clamp to 16 bits
    always_comb begin
        w_ybias = {r_y[SIG_W-1], r_y}
                + $signed({{(SIG_W+1-SIG_FRAC){1'b0}}, {SIG_FRAC{r_y[SIG_W-1]}}});
        w_q     = w_ybias[SIG_W:SIG_FRAC];
        if ((&w_q[SIG_W-SIG_FRAC:SAMPLE_W-1]) || !(|w_q[SIG_W-SIG_FRAC:SAMPLE_W-1])) begin
            w_qsat = w_q[SAMPLE_W-1:0];
        end else begin
            w_qsat = w_q[SIG_W-SIG_FRAC] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                         : {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= {{(SIG_W-SAMPLE_W-SIG_FRAC){i_sample_in[SAMPLE_W-1]}},
                    i_sample_in, {SIG_FRAC{1'b0}}};
        end else if (i_cmd.stage_adv) begin
            r_x <= r_y;
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_aligned;
        end
        r_acc <= n_acc;
        if (i_cmd.y_load) begin
            r_y <= w_ysat;
        end
        if (i_cmd.out_load) begin
            r_out <= w_qsat;
        end
    end

    // delay state, cleared by reset and at chunk start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < N_STAGE; s++) begin
                r_d0[s] <= '0;
                r_d1[s] <= '0;
            end
        end else if (i_cmd.load && i_chunk_start) begin
            for (int s = 0; s < N_STAGE; s++) begin
                r_d0[s] <= '0;
                r_d1[s] <= '0;
            end
        end else begin
            if (i_cmd.d0_wr) begin
                r_d0[i_cmd.stage] <= r_acc;
            end
            if (i_cmd.d1_wr) begin
                r_d1[i_cmd.stage] <= r_acc;
            end
        end
    end

    // chunk start leaves every delay at zero before filtering begins
    a_chunk_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && i_chunk_start) |=>
            ((r_d0[0] == '0) && (r_d1[0] == '0) && (r_d0[1] == '0) && (r_d1[1] == '0)))
        else $error("delay state not cleared at chunk start");

    // delay writes, products and stage-output loads never collide with a new sample load
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> !(i_cmd.d0_wr || i_cmd.d1_wr || i_cmd.mul_en || i_cmd.y_load))
        else $error("sample loaded while datapath busy");

endmodule
